[hw/rtl/gauss_elimination_solver_defines.svh]
// Assertion macros for the solver RTL.
`ifndef GAUSS_ELIMINATION_SOLVER_DEFINES_SVH
`define GAUSS_ELIMINATION_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define GES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GES_NEVER(lbl, expr, msg) \
  `GES_ASSERT(lbl, !(expr), msg)
`else
`define GES_ASSERT(lbl, prop, msg)
`define GES_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/ges_pkg.sv]
`default_nettype none
package ges_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int SIZE_W    = 4;
  localparam int THR_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR  = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_CMP,
    S_PIV_CHK,
    S_ELM_RD_A,
    S_ELM_GO,
    S_ELM_WAIT,
    S_ELM_RD_P,
    S_ELM_RD_I,
    S_ELM_WR,
    S_BS_ROW,
    S_BS_RD_A,
    S_BS_MUL,
    S_BS_ACC,
    S_BS_RD_N,
    S_BS_SUB,
    S_BS_RD_D,
    S_BS_GO,
    S_BS_WAIT,
    S_EMIT,
    S_SING
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/ges_mul.sv]
`default_nettype none
// Registered fixed-point product, floor shift and saturation.
module ges_mul
  import ges_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                     clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]      y,
  output logic                    sat
);

  localparam logic signed [63:0] HI = 64'sd2147483647;
  localparam logic signed [63:0] LO = -64'sd2147483648;

  logic signed [63:0] prod;
  logic signed [63:0] sh;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_comb begin
    sh  = prod >>> FRAC_BITS;
    sat = (sh > HI) || (sh < LO);
    if (sh > HI) begin
      y = SAT_MAX;
    end else if (sh < LO) begin
      y = SAT_MIN;
    end else begin
      y = sh[31:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ges_div.sv]
`default_nettype none
// Bit-serial signed divide: (a << FRAC_BITS) / b, truncated, saturated.
module ges_div
  import ges_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      q,
  output logic                    sat
);

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] quo;
  logic [31:0]      rem;
  logic [31:0]      dmag;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      rem_sh;
  logic             ge;
  logic [31:0]      amag;

  always_comb begin
    amag   = a[31] ? (~a + 32'd1) : a;
    rem_sh = {rem, quo[NUM_W-1]};
    ge     = rem_sh >= {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= NUM_W'(amag) << FRAC_BITS;
        dmag <= b[31] ? (~b + 32'd1) : b;
        neg  <= a[31] ^ b[31];
      end else if (busy) begin
        rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude limit is one larger on the negative side
  always_comb begin
    sat = neg ? (quo > NUM_W'(33'h0_8000_0000)) : (quo > NUM_W'(33'h0_7FFF_FFFF));
    if (sat) begin
      q = neg ? SAT_MIN : SAT_MAX;
    end else begin
      q = neg ? (~quo[31:0] + 32'd1) : quo[31:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gauss_elimination_solver.sv]
// Linear solver for A x = f, n up to MAX_SIZE, signed fixed point with FRAC_BITS
// fraction bits. Write matrix_size (index 0) and pivot_threshold (index 1) while
// idle; the config channel is ready only in the load state, and a config beat
// there holds off the input beat of the same cycle. Then send the augmented
// matrix row-major, one beat per entry, rhs last in each row; loading takes one
// beat per cycle. After the last entry the block stops taking beats, eliminates
// with max-magnitude row pivoting, back-substitutes and sends x[0..n-1] with
// last on x[n-1], or a single beat with status 1 if a pivot is below the
// threshold (or zero). Status 2 marks a system in which any value saturated.
// Solve time is set by the matrix RAM (one read and one write port) and the
// bit-serial divider (one division per eliminated row and one per unknown);
// the number of entry updates grows as n^3 and of divisions as about n^2/2.
`default_nettype none
`include "gauss_elimination_solver_defines.svh"
module gauss_elimination_solver
  import ges_pkg::*;
#(
  parameter int MAX_SIZE  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire logic signed [31:0]      coefficient,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [31:0]           solution,
  output logic [2:0]                   unknown_index,
  output logic [1:0]                   status,
  output logic                         last,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DAT_W-1:0]    cfg_data
);

  localparam int ROW_STRIDE = MAX_SIZE + 1;
  localparam int DEPTH      = MAX_SIZE * ROW_STRIDE;
  localparam int AW         = $clog2(DEPTH);
  localparam int RW         = $clog2(MAX_SIZE);
  localparam int CW         = $clog2(MAX_SIZE + 1);
  localparam int ACC_W      = DATA_W + $clog2(MAX_SIZE);
  localparam logic signed [ACC_W:0] BS_MAX = (ACC_W+1)'(64'sd2147483647);
  localparam logic signed [ACC_W:0] BS_MIN = (ACC_W+1)'(-64'sd2147483648);

  // config
  logic [SIZE_W-1:0] msize;
  logic [THR_W-1:0]  thr;
  logic [CW-1:0]     n_eff;
  logic [RW-1:0]     n_last;

  // sequencer
  state_t state, state_next;
  logic [RW-1:0] ld_r, k, i, best, best_phys, k_phys;
  logic [CW-1:0] ld_c, j;
  logic [RW-1:0] perm [MAX_SIZE];
  logic [RW-1:0] perm_i;
  logic [31:0]   pm;
  logic signed [31:0] pv, s, tsub;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] sol [MAX_SIZE];
  logic [RW-1:0] oi;
  logic          sat_flag;

  // matrix RAM
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata, wdata;
  logic [AW-1:0]      raddr, waddr;
  logic               mem_we;
  logic [RW-1:0]      rd_row;
  logic [CW-1:0]      rd_col;

  // units
  logic               div_start, div_busy, div_done, div_sat;
  logic signed [31:0] div_a, div_b, div_q;
  logic signed [31:0] mul_a, mul_b, mul_y;
  logic               mul_sat;

  logic               in_acc, ld_last, out_load, piv_sing;
  logic [31:0]        rd_mag;
  logic signed [32:0] e_diff;
  logic               e_ovf;
  logic signed [31:0] e_val;
  logic signed [ACC_W:0] bs_diff;
  logic               bs_ovf;
  logic signed [31:0] bs_val;
  logic [RW-1:0]      sol_idx;

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] row, logic [CW-1:0] col);
    cell_addr = AW'(int'(row) * ROW_STRIDE + int'(col));
  endfunction

  always_comb begin
    if (msize == '0) begin
      n_eff = CW'(1);
    end else if (int'(msize) > MAX_SIZE) begin
      n_eff = CW'(MAX_SIZE);
    end else begin
      n_eff = CW'(msize);
    end
    n_last = RW'(n_eff - CW'(1));
  end

  assign cfg_ready = (state == S_LOAD);
  assign perm_i    = perm[i];
  assign in_acc    = in_valid && in_ready;
  assign ld_last   = (ld_r == n_last) && (ld_c == n_eff);
  assign out_load  = ((state == S_EMIT) || (state == S_SING)) && (!out_valid || out_ready);
  assign rd_mag    = rdata[31] ? (~rdata + 32'd1) : rdata;
  assign piv_sing  = (pv == '0) || (pm < {16'd0, thr});
  assign sol_idx   = (state == S_EMIT) ? oi : RW'(j);

  // entry update: a[i][j] - pivot-row product; back-substitution: rhs - row sum
  always_comb begin
    e_diff = {rdata[31], rdata} - {mul_y[31], mul_y};
    e_ovf  = e_diff[32] ^ e_diff[31];
    e_val  = e_ovf ? (e_diff[32] ? SAT_MIN : SAT_MAX) : e_diff[31:0];
    bs_diff = {{(ACC_W+1-DATA_W){rdata[31]}}, rdata} - {acc[ACC_W-1], acc};
    bs_ovf  = (bs_diff > BS_MAX) || (bs_diff < BS_MIN);
    if (bs_diff > BS_MAX) begin
      bs_val = SAT_MAX;
    end else if (bs_diff < BS_MIN) begin
      bs_val = SAT_MIN;
    end else begin
      bs_val = bs_diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  ges_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .a    (div_a),
    .b    (div_b),
    .busy (div_busy),
    .done (div_done),
    .q    (div_q),
    .sat  (div_sat)
  );

  ges_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .y  (mul_y),
    .sat(mul_sat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (in_acc && ld_last) state_next = S_PIV_RD;
      S_PIV_RD:   state_next = S_PIV_CMP;
      S_PIV_CMP:  state_next = (i == n_last) ? S_PIV_CHK : S_PIV_RD;
      S_PIV_CHK: begin
        if (piv_sing) begin
          state_next = S_SING;
        end else if (k == n_last) begin
          state_next = S_BS_ROW;
        end else begin
          state_next = S_ELM_RD_A;
        end
      end
      S_ELM_RD_A: state_next = S_ELM_GO;
      S_ELM_GO:   state_next = S_ELM_WAIT;
      S_ELM_WAIT: if (div_done) state_next = S_ELM_RD_P;
      S_ELM_RD_P: state_next = S_ELM_RD_I;
      S_ELM_RD_I: state_next = S_ELM_WR;
      S_ELM_WR: begin
        if (j != n_eff) begin
          state_next = S_ELM_RD_P;
        end else if (i == n_last) begin
          state_next = S_PIV_RD;
        end else begin
          state_next = S_ELM_RD_A;
        end
      end
      S_BS_ROW:   state_next = (j < n_eff) ? S_BS_RD_A : S_BS_RD_N;
      S_BS_RD_A:  state_next = S_BS_MUL;
      S_BS_MUL:   state_next = S_BS_ACC;
      S_BS_ACC:   state_next = S_BS_ROW;
      S_BS_RD_N:  state_next = S_BS_SUB;
      S_BS_SUB:   state_next = S_BS_RD_D;
      S_BS_RD_D:  state_next = S_BS_GO;
      S_BS_GO:    state_next = S_BS_WAIT;
      S_BS_WAIT:  if (div_done) state_next = (i == '0) ? S_EMIT : S_BS_ROW;
      S_EMIT:     if (out_load && (oi == n_last)) state_next = S_LOAD;
      S_SING:     if (out_load) state_next = S_LOAD;
      default:    state_next = S_LOAD;
    endcase
  end

  // RAM, divider and multiplier controls
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    waddr     = cell_addr(ld_r, ld_c);
    wdata     = coefficient;
    rd_row    = perm_i;
    rd_col    = j;
    div_start = 1'b0;
    div_a     = rdata;
    div_b     = pv;
    mul_a     = rdata;
    mul_b     = s;
    unique case (state)
      S_LOAD: begin
        // a config beat goes first
        in_ready = !cfg_valid;
        mem_we   = in_valid && !cfg_valid;
      end
      S_PIV_RD, S_ELM_RD_A:  rd_col = CW'(k);
      S_ELM_GO:              div_start = 1'b1;
      S_ELM_RD_P:            rd_row = best_phys;
      S_ELM_WR: begin
        mem_we = 1'b1;
        waddr  = cell_addr(perm_i, j);
        wdata  = e_val;
      end
      S_BS_MUL:              mul_b = sol[sol_idx];
      S_BS_RD_N:             rd_col = n_eff;
      S_BS_RD_D:             rd_col = CW'(i);
      S_BS_GO: begin
        div_start = 1'b1;
        div_a     = tsub;
        div_b     = rdata;
      end
      default: ;
    endcase
    raddr = cell_addr(rd_row, rd_col);
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      msize     <= SIZE_W'(8);
      thr       <= THR_W'(1);
      ld_r      <= '0;
      ld_c      <= '0;
      out_valid <= 1'b0;
      sat_flag  <= 1'b0;
      for (int q = 0; q < MAX_SIZE; q++) begin
        perm[q] <= RW'(q);
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (ld_c == n_eff) begin
              ld_c <= '0;
              ld_r <= ld_last ? '0 : ld_r + 1'b1;
            end else begin
              ld_c <= ld_c + 1'b1;
            end
            if (ld_last) begin
              k        <= '0;
              i        <= '0;
              sat_flag <= 1'b0;
              for (int q = 0; q < MAX_SIZE; q++) begin
                perm[q] <= RW'(q);
              end
            end
          end
        end
        S_PIV_CMP: begin
          if ((i == k) || (rd_mag > pm)) begin
            pm        <= rd_mag;
            pv        <= rdata;
            best      <= i;
            best_phys <= perm_i;
          end
          if (i == k) begin
            k_phys <= perm_i;
          end
          i <= i + 1'b1;
        end
        S_PIV_CHK: begin
          if (!piv_sing) begin
            if (best != k) begin
              perm[k]    <= best_phys;
              perm[best] <= k_phys;
            end
            if (k == n_last) begin
              i   <= n_last;
              j   <= n_eff;
              acc <= '0;
            end else begin
              i <= k + 1'b1;
            end
          end
        end
        S_ELM_WAIT: begin
          if (div_done) begin
            s        <= div_q;
            sat_flag <= sat_flag | div_sat;
            j        <= CW'(k) + 1'b1;
          end
        end
        S_ELM_WR: begin
          sat_flag <= sat_flag | mul_sat | e_ovf;
          j        <= j + 1'b1;
          if (j == n_eff) begin
            if (i == n_last) begin
              k <= k + 1'b1;
              i <= k + 1'b1;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        S_BS_ACC: begin
          acc      <= acc + {{(ACC_W-DATA_W){mul_y[31]}}, mul_y};
          sat_flag <= sat_flag | mul_sat;
          j        <= j + 1'b1;
        end
        S_BS_SUB: begin
          tsub     <= bs_val;
          sat_flag <= sat_flag | bs_ovf;
        end
        S_BS_WAIT: begin
          if (div_done) begin
            sol[i]   <= div_q;
            sat_flag <= sat_flag | div_sat;
            oi       <= '0;
            if (i != '0) begin
              i   <= i - 1'b1;
              j   <= CW'(i);
              acc <= '0;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            solution      <= sol[sol_idx];
            unknown_index <= 3'(oi);
            status        <= sat_flag ? STATUS_SATURATED : STATUS_OK;
            last          <= (oi == n_last);
            oi            <= oi + 1'b1;
          end
        end
        S_SING: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            solution      <= '0;
            unknown_index <= '0;
            status        <= STATUS_SINGULAR;
            last          <= 1'b1;
          end
        end
        default: ;
      endcase
      // config beats arrive only while idle; a size write restarts the load
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MATRIX_SIZE: begin
            msize <= cfg_data[SIZE_W-1:0];
            ld_r  <= '0;
            ld_c  <= '0;
          end
          REG_PIVOT_THRESHOLD: thr <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  `GES_ASSERT(a_div_done_waited, div_done |-> (state == S_ELM_WAIT || state == S_BS_WAIT),
    "divider result with nobody waiting")
  `GES_ASSERT(a_we_owner, mem_we |-> (state == S_ELM_WR || (state == S_LOAD && in_valid)),
    "matrix write outside load or update")
  `GES_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(solution) && $stable(unknown_index) && $stable(status) && $stable(last)),
    "result beat changed while waiting")
  `GES_NEVER(a_load_div_idle, (state == S_LOAD) && div_busy,
    "divider still busy while loading")

endmodule
`default_nettype wire
